// File: src/trab_pkg.sv
// ----------------------------------------------------------------------------
// trab_pkg
// Shared types and constants of the register-file ALU and branch unit.
// ----------------------------------------------------------------------------
`default_nettype none

package trab_pkg;

   // default sizes, used as defaults of the top level parameters
   localparam int NUM_REGS_DEF     = 10;
   localparam int DATA_WIDTH_DEF   = 32;
   localparam int TARGET_WIDTH_DEF = 16;

   // fixed widths of the channel fields
   localparam int IMM_WIDTH    = 32;
   localparam int RESULT_WIDTH = 32;
   localparam int TGT_WIDTH    = 16;
   localparam int REG_IDX_W    = 4;
   localparam int OPCODE_W     = 3;

   // entries of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   localparam logic KIND_ALU    = 1'b0;
   localparam logic KIND_BRANCH = 1'b1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_MOV = 3'd0,
      OP_ADD = 3'd1,
      OP_SUB = 3'd2,
      OP_MUL = 3'd3,
      OP_DIV = 3'd4,
      OP_AND = 3'd5,
      OP_OR  = 3'd6,
      OP_CMP = 3'd7
   } alu_op_type;

   typedef enum logic [OPCODE_W-1:0] {
      BR_JMP = 3'd0,
      BR_JL  = 3'd1,
      BR_JLE = 3'd2,
      BR_JG  = 3'd3,
      BR_JGE = 3'd4,
      BR_JE  = 3'd5
   } br_op_type;

   // what the back end has to do with an item
   typedef enum logic [1:0] {
      CLS_SKIP   = 2'd0,   // destination out of range, nothing is written
      CLS_HOLD   = 2'd1,   // source register out of range, report destination
      CLS_EXEC   = 2'd2,   // regular alu operation
      CLS_BRANCH = 2'd3
   } cls_type;

   typedef struct packed {
      logic                        kind;
      logic [OPCODE_W-1:0]         opcode;
      logic [REG_IDX_W-1:0]        dest_reg;
      logic [REG_IDX_W-1:0]        source_reg;
      logic                        use_immediate;
      logic signed [IMM_WIDTH-1:0] immediate;
      logic [TGT_WIDTH-1:0]        branch_target;
   } req_item_type;

   typedef struct packed {
      logic signed [RESULT_WIDTH-1:0] result_value;
      logic signed [RESULT_WIDTH-1:0] flag_value;
      logic                           branch_taken;
      logic [TGT_WIDTH-1:0]           next_target;
      logic                           divide_error;
   } rsp_item_type;

   typedef struct packed {
      cls_type                     cls;
      logic [OPCODE_W-1:0]         opcode;
      logic [REG_IDX_W-1:0]        dest_reg;
      logic [REG_IDX_W-1:0]        source_reg;
      logic                        use_immediate;
      logic signed [IMM_WIDTH-1:0] immediate;
      logic [TGT_WIDTH-1:0]        target;
   } dec_item_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } mdu_ctl_type;

endpackage

`default_nettype wire

// File: src/trab_if.sv
// ----------------------------------------------------------------------------
// trab_req_if / trab_rsp_if
// Valid/ready channels carrying instruction items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface trab_req_if import trab_pkg::*;;
   logic         valid;
   logic         ready;
   req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface trab_rsp_if import trab_pkg::*;;
   logic         valid;
   logic         ready;
   rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/trab_front.sv
// ----------------------------------------------------------------------------
// trab_front
// Takes instruction items and classifies them for the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module trab_front import trab_pkg::*; #(
   parameter int NUM_REGS     = NUM_REGS_DEF,
   parameter int TARGET_WIDTH = TARGET_WIDTH_DEF
) (
   trab_req_if.sink     req,
   input  logic         q_full,
   output logic         q_push,
   output dec_item_type q_data
);

   logic dest_ok;
   logic src_ok;
   logic [TGT_WIDTH-1:0] tgt_masked;

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   assign dest_ok = {1'b0, req.payload.dest_reg} < (REG_IDX_W+1)'(NUM_REGS);
   assign src_ok  = req.payload.use_immediate ||
                    ({1'b0, req.payload.source_reg} < (REG_IDX_W+1)'(NUM_REGS));

   always_comb begin
      for (int i = 0; i < TGT_WIDTH; i++) begin
         tgt_masked[i] = (i < TARGET_WIDTH) ? req.payload.branch_target[i] : 1'b0;
      end
   end

   always_comb begin
      q_data.opcode        = req.payload.opcode;
      q_data.dest_reg      = req.payload.dest_reg;
      q_data.source_reg    = req.payload.source_reg;
      q_data.use_immediate = req.payload.use_immediate;
      q_data.immediate     = req.payload.immediate;
      q_data.target        = tgt_masked;
      priority if (req.payload.kind == KIND_BRANCH) begin
         q_data.cls = CLS_BRANCH;
      end else if (!dest_ok) begin
         q_data.cls = CLS_SKIP;
      end else if (!src_ok) begin
         q_data.cls = CLS_HOLD;
      end else begin
         q_data.cls = CLS_EXEC;
      end
   end

endmodule

`default_nettype wire

// File: src/trab_queue.sv
// ----------------------------------------------------------------------------
// trab_queue
// Short queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module trab_queue import trab_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  dec_item_type push_data,
   output logic         full,
   input  logic         pop,
   output logic         not_empty,
   output dec_item_type head
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   dec_item_type    slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full      = count_ff == CW'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: src/trab_muldiv.sv
// ----------------------------------------------------------------------------
// trab_muldiv
// Bit-serial multiplier (low half, shift and add) and signed restoring
// divider; one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module trab_muldiv import trab_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mdu_ctl_type                  ctl,
   input  logic signed [DATA_WIDTH-1:0] opa,
   input  logic signed [DATA_WIDTH-1:0] opb,
   output logic                         busy,
   output logic signed [DATA_WIDTH-1:0] result
);

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W);

   logic          busy_ff;
   logic          is_div_ff;
   logic          neg_ff;
   logic [CW-1:0] cnt_ff;
   logic [W-1:0]  acc_ff;   // product, or partial remainder
   logic [W-1:0]  xa_ff;    // multiplicand, or dividend shifting into quotient
   logic [W-1:0]  xb_ff;    // multiplier, or divisor magnitude
   logic [W-1:0]  mag_a;
   logic [W-1:0]  mag_b;
   logic [W-1:0]  rem_sh;
   logic          rem_ge;

   assign mag_a  = opa[W-1] ? W'(-opa) : opa;
   assign mag_b  = opb[W-1] ? W'(-opb) : opb;
   assign rem_sh = {acc_ff[W-2:0], xa_ff[W-1]};
   assign rem_ge = rem_sh >= xb_ff;

   assign busy   = busy_ff;
   assign result = is_div_ff ? (neg_ff ? W'(-xa_ff) : xa_ff) : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == '0) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         is_div_ff <= ctl.is_div;
         neg_ff    <= opa[W-1] ^ opb[W-1];
         cnt_ff    <= CW'(W - 1);
         acc_ff    <= '0;
         xa_ff     <= ctl.is_div ? mag_a : opa;
         xb_ff     <= ctl.is_div ? mag_b : opb;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (is_div_ff) begin
            acc_ff <= rem_ge ? rem_sh - xb_ff : rem_sh;
            xa_ff  <= {xa_ff[W-2:0], rem_ge};
         end else begin
            if (xb_ff[0]) begin
               acc_ff <= acc_ff + xa_ff;
            end
            xa_ff <= {xa_ff[W-2:0], 1'b0};
            xb_ff <= {1'b0, xb_ff[W-1:1]};
         end
      end
   end

endmodule

`default_nettype wire

// File: src/trab_back.sv
// ----------------------------------------------------------------------------
// trab_back
// Execution back end: register file, flag, alu, branch check, result
// register, and the serial multiply/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

module trab_back import trab_pkg::*; #(
   parameter int NUM_REGS   = NUM_REGS_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  dec_item_type q_head,
   output logic         q_pop,
   trab_rsp_if.source   rsp
);

   localparam int W         = DATA_WIDTH;
   localparam int FLAG_IDX  = NUM_REGS - 1;
   localparam int MEM_DEPTH = NUM_REGS - 1;
   localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_OPER,
      ST_WAIT
   } state_type;

   state_type             state_ff, state_in;
   dec_item_type          cur_ff;
   logic [W-1:0]          mem_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0]  mem_vld_ff;
   logic signed [W-1:0]   flag_ff;
   logic [W-1:0]          a_raw_ff, s_raw_ff;
   logic                  a_vld_ff, s_vld_ff;
   logic                  rsp_valid_ff;
   rsp_item_type          rsp_pl_ff, rsp_in;

   logic [MEM_AW-1:0]     a_addr, s_addr, w_addr;
   logic                  dest_is_flag, src_is_flag;
   logic signed [W-1:0]   a_val, src_val, alu_res, cmp_val;
   logic                  br_hit;
   alu_op_type            alu_op;
   br_op_type             br_op;

   logic                  fin_valid, fin_write, cmp_en, fin_taken, fin_derr;
   logic signed [W-1:0]   fin_result, flag_next;
   logic                  out_free, commit, mem_we;

   mdu_ctl_type           mdu_ctl;
   logic                  mdu_busy;
   logic signed [W-1:0]   mdu_result;

   trab_muldiv #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mdu_ctl),
      .opa    (a_val),
      .opb    (src_val),
      .busy   (mdu_busy),
      .result (mdu_result)
   );

   // flag index and out-of-range indexes never address the array
   assign a_addr = ({1'b0, q_head.dest_reg} < (REG_IDX_W+1)'(MEM_DEPTH)) ?
                   q_head.dest_reg[MEM_AW-1:0] : '0;
   assign s_addr = ({1'b0, q_head.source_reg} < (REG_IDX_W+1)'(MEM_DEPTH)) ?
                   q_head.source_reg[MEM_AW-1:0] : '0;
   assign w_addr = cur_ff.dest_reg[MEM_AW-1:0];

   assign q_pop = (state_ff == ST_IDLE) && q_valid;

   assign dest_is_flag = cur_ff.dest_reg == REG_IDX_W'(FLAG_IDX);
   assign src_is_flag  = cur_ff.source_reg == REG_IDX_W'(FLAG_IDX);

   // entries never written read as zero
   assign a_val = dest_is_flag ? flag_ff : (a_vld_ff ? a_raw_ff : '0);
   always_comb begin
      priority if (cur_ff.use_immediate) begin
         src_val = W'(cur_ff.immediate);
      end else if (src_is_flag) begin
         src_val = flag_ff;
      end else begin
         src_val = s_vld_ff ? s_raw_ff : '0;
      end
   end

   assign alu_op = alu_op_type'(cur_ff.opcode);
   assign br_op  = br_op_type'(cur_ff.opcode);

   always_comb begin
      unique case (alu_op)
         OP_MOV:  alu_res = src_val;
         OP_ADD:  alu_res = a_val + src_val;
         OP_SUB:  alu_res = a_val - src_val;
         OP_AND:  alu_res = a_val & src_val;
         OP_OR:   alu_res = a_val | src_val;
         default: alu_res = a_val;
      endcase
   end

   always_comb begin
      priority if (a_val < src_val) begin
         cmp_val = '1;
      end else if (src_val < a_val) begin
         cmp_val = W'(1);
      end else begin
         cmp_val = '0;
      end
   end

   // conditional branches look for the exact flag codes
   always_comb begin
      unique case (br_op)
         BR_JMP:  br_hit = 1'b1;
         BR_JL:   br_hit = flag_ff == '1;
         BR_JLE:  br_hit = (flag_ff == '1) || (flag_ff == '0);
         BR_JG:   br_hit = flag_ff == W'(1);
         BR_JGE:  br_hit = (flag_ff == W'(1)) || (flag_ff == '0);
         BR_JE:   br_hit = flag_ff == '0;
         default: br_hit = 1'b0;
      endcase
   end

   always_comb begin
      fin_valid  = 1'b0;
      fin_write  = 1'b0;
      cmp_en     = 1'b0;
      fin_taken  = 1'b0;
      fin_derr   = 1'b0;
      fin_result = '0;
      mdu_ctl    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            fin_valid = 1'b0;
         end
         ST_OPER: begin
            unique case (cur_ff.cls)
               CLS_SKIP: begin
                  fin_valid = 1'b1;
               end
               CLS_HOLD: begin
                  fin_valid  = 1'b1;
                  fin_result = a_val;
               end
               CLS_BRANCH: begin
                  fin_valid = 1'b1;
                  fin_taken = br_hit;
               end
               CLS_EXEC: begin
                  unique case (alu_op)
                     OP_MUL: begin
                        mdu_ctl.start = 1'b1;
                     end
                     OP_DIV: begin
                        if (src_val == '0) begin
                           fin_valid  = 1'b1;
                           fin_derr   = 1'b1;
                           fin_result = a_val;
                        end else begin
                           mdu_ctl.start  = 1'b1;
                           mdu_ctl.is_div = 1'b1;
                        end
                     end
                     OP_CMP: begin
                        fin_valid  = 1'b1;
                        cmp_en     = 1'b1;
                        // a compare into the flag reports the new flag
                        fin_result = dest_is_flag ? cmp_val : a_val;
                     end
                     default: begin
                        fin_valid  = 1'b1;
                        fin_write  = 1'b1;
                        fin_result = alu_res;
                     end
                  endcase
               end
            endcase
         end
         ST_WAIT: begin
            fin_valid  = !mdu_busy;
            fin_write  = 1'b1;
            fin_result = mdu_result;
         end
         default: begin
            fin_valid = 1'b0;
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign commit   = fin_valid && out_free;
   assign mem_we   = commit && fin_write && !dest_is_flag;

   always_comb begin
      priority if (commit && fin_write && dest_is_flag) begin
         flag_next = fin_result;
      end else if (commit && cmp_en) begin
         flag_next = cmp_val;
      end else begin
         flag_next = flag_ff;
      end
   end

   always_comb begin
      rsp_in.result_value = RESULT_WIDTH'(fin_result);
      rsp_in.flag_value   = RESULT_WIDTH'(flag_next);
      rsp_in.branch_taken = fin_taken;
      rsp_in.next_target  = fin_taken ? cur_ff.target : '0;
      rsp_in.divide_error = fin_derr;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_OPER;
            end
         end
         ST_OPER: begin
            priority if (mdu_ctl.start) begin
               state_in = ST_WAIT;
            end else if (commit) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_OPER;
            end
         end
         ST_WAIT: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mem_vld_ff   <= '0;
         flag_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         flag_ff  <= flag_next;
         if (mem_we) begin
            mem_vld_ff[w_addr] <= 1'b1;
         end
         if (q_pop) begin
            cur_ff   <= q_head;
            a_vld_ff <= mem_vld_ff[a_addr];
            s_vld_ff <= mem_vld_ff[s_addr];
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
            rsp_pl_ff    <= rsp_in;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // register file: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[w_addr] <= fin_result;
      end
      if (q_pop) begin
         a_raw_ff <= mem_ff[a_addr];
         s_raw_ff <= mem_ff[s_addr];
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_pl_ff;

endmodule

`default_nettype wire

// File: src/toy_register_alu_branch_unit.sv
// ----------------------------------------------------------------------------
// toy_register_alu_branch_unit
// Executes decoded alu and branch instructions on a small register file
// whose last entry is the compare flag.
// ----------------------------------------------------------------------------
// Every instruction item returns exactly one result item, in order. The front
// classifies items into a two-entry queue and keeps taking them while the
// back end works. The back end runs one item at a time: mov, add, sub, and,
// or, cmp, a divide by zero and all branches go through a register read,
// then execute into the output register; mul and div go through a shared
// one-bit-per-cycle unit. The output register lets a finished result wait
// while the next item is already being executed. The register file and
// flag read as zero after reset.
`default_nettype none

module toy_register_alu_branch_unit import trab_pkg::*; #(
   parameter int NUM_REGS     = NUM_REGS_DEF,
   parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
   parameter int TARGET_WIDTH = TARGET_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   trab_req_if.sink   req_chan,
   trab_rsp_if.source rsp_chan
);

   logic         q_push;
   dec_item_type q_push_data;
   logic         q_full;
   logic         q_pop;
   logic         q_not_empty;
   dec_item_type q_head;

   trab_front #(
      .NUM_REGS     (NUM_REGS),
      .TARGET_WIDTH (TARGET_WIDTH)
   ) u_front (
      .req    (req_chan),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_push_data)
   );

   trab_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   trab_back #(
      .NUM_REGS   (NUM_REGS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_not_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule

`default_nettype wire
